@@ src/usbc_rha_pkg.sv @@
// shared types and constants for the usb-c role handover arbiter
package usbc_rha_pkg;

    // timestamp and configuration widths
    localparam int TIME_W  = 32;
    localparam int SEC_W   = 8;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // default for all second counts after reset
    localparam logic [SEC_W-1:0] DEFAULT_SECONDS = SEC_W'(3);

    // role register write commands
    typedef enum logic [CMD_W-1:0] {
        CMD_NONE = 2'd0,
        CMD_SINK = 2'd1,
        CMD_DUAL = 2'd2
    } role_cmd_t;

    // register indexes (byte address / 4)
    typedef enum logic [1:0] {
        REG_CTRL_MODE = 2'd0,
        REG_HANDOVER  = 2'd1,
        REG_RELEASE   = 2'd2,
        REG_ID_SETTLE = 2'd3
    } reg_idx_t;

endpackage

@@ src/usbc_role_handover_arbiter_unit.sv @@
// top level of the usb-c role handover arbiter
//
//  channel | direction | ports                                  | handshake
//  --------+-----------+----------------------------------------+------------------
//  s_      | in        | poll flags, s_now_seconds              | s_valid / s_ready
//  m_      | out       | m_role_command, m_id_distrusted        | m_valid / m_ready
//  apb     | in        | psel penable pwrite paddr pwdata prdata| pready tied high
//
// one poll word per cycle sustained while m_ready stays high; a word is registered on input,
// evaluated against the tracking state and lands in the result register. the input and
// result registers keep the two sides apart: a new word is taken while a result waits,
// and both stall only when both registers are full.
// reset (aresetn, synchronous) clears the tracking state and loads the config defaults.
module usbc_role_handover_arbiter_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // poll words
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_audio_present,
    input  logic                                 s_typec_partner,
    input  logic                                 s_host_bus_device,
    input  logic                                 s_id_line_host,
    input  logic                                 s_vbus_present,
    input  logic                                 s_port_is_dual_now,
    input  logic [usbc_rha_pkg::TIME_W-1:0]      s_now_seconds,
    // command words
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [usbc_rha_pkg::CMD_W-1:0]       m_role_command,
    output logic                                 m_id_distrusted,
    // configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [usbc_rha_pkg::ADDR_W-1:0]      paddr,
    input  logic [usbc_rha_pkg::DATA_W-1:0]      pwdata,
    output logic [usbc_rha_pkg::DATA_W-1:0]      prdata,
    output logic                                 pready
);
    import usbc_rha_pkg::*;

    // configuration registers
    logic             ctrl_mode_reg;
    logic [SEC_W-1:0] handover_reg;
    logic [SEC_W-1:0] release_reg;
    logic [SEC_W-1:0] settle_reg;

    // input register
    logic              in_vld_reg;
    logic              audio_reg, partner_reg, host_bus_reg, id_host_reg, vbus_reg, dual_reg;
    logic [TIME_W-1:0] now_reg;

    // tracking state
    logic              attach_vld_reg, attach_vld_next;
    logic [TIME_W-1:0] attach_time_reg, attach_time_next;
    logic              empty_vld_reg, empty_vld_next;
    logic [TIME_W-1:0] empty_time_reg, empty_time_next;
    logic              sink_vld_reg, sink_vld_next;
    logic [TIME_W-1:0] sink_time_reg, sink_time_next;
    logic              untrusted_reg, untrusted_next;

    // result register
    logic              out_vld_reg;
    role_cmd_t         cmd_reg, cmd_next;
    logic              distrust_reg;

    logic              proc;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // handshake
    assign proc    = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || proc;
    assign m_valid = out_vld_reg;
    assign m_role_command  = cmd_reg;
    assign m_id_distrusted = distrust_reg;

    // apb access
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (cfg_idx)
            REG_CTRL_MODE: prdata = DATA_W'(ctrl_mode_reg);
            REG_HANDOVER:  prdata = DATA_W'(handover_reg);
            REG_RELEASE:   prdata = DATA_W'(release_reg);
            REG_ID_SETTLE: prdata = DATA_W'(settle_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_mode_reg <= 1'b0;
            handover_reg  <= DEFAULT_SECONDS;
            release_reg   <= DEFAULT_SECONDS;
            settle_reg    <= DEFAULT_SECONDS;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_CTRL_MODE: ctrl_mode_reg <= pwdata[0];
                REG_HANDOVER:  handover_reg  <= pwdata[SEC_W-1:0];
                REG_RELEASE:   release_reg   <= pwdata[SEC_W-1:0];
                REG_ID_SETTLE: settle_reg    <= pwdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    // poll evaluation
    logic [TIME_W-1:0] el_attach, el_empty, el_sink;
    logic [SEC_W:0]    window;
    logic              seen, empty;

    assign el_attach = now_reg - attach_time_reg;
    assign el_empty  = now_reg - empty_time_reg;
    assign el_sink   = now_reg - sink_time_reg;
    assign window    = {1'b0, release_reg} + {1'b0, settle_reg};

    always_comb begin
        attach_vld_next  = attach_vld_reg;
        attach_time_next = attach_time_reg;
        empty_vld_next   = empty_vld_reg;
        empty_time_next  = empty_time_reg;
        sink_vld_next    = sink_vld_reg;
        sink_time_next   = sink_time_reg;
        untrusted_next   = untrusted_reg;
        cmd_next         = CMD_NONE;
        seen             = 1'b0;
        empty            = 1'b1;

        // presence, with the id line rules in controller mode
        if (!ctrl_mode_reg) begin
            seen = partner_reg;
        end else if (host_bus_reg) begin
            seen = 1'b1;
        end else if (untrusted_reg || !id_host_reg) begin
            seen = 1'b0;
        end else if (!dual_reg && sink_vld_reg && el_sink >= TIME_W'(settle_reg)) begin
            seen = 1'b0;
            if (!audio_reg) begin
                untrusted_next = 1'b1;
            end
        end else begin
            seen = 1'b1;
        end

        if (audio_reg) begin
            // sound card keeps the port dual
            attach_vld_next = 1'b0;
            empty_vld_next  = 1'b0;
            if (!dual_reg) begin
                cmd_next = CMD_DUAL;
            end
        end else if (seen) begin
            // partner present: hand over after the handover time
            empty_vld_next = 1'b0;
            if (!attach_vld_reg) begin
                attach_vld_next  = 1'b1;
                attach_time_next = now_reg;
            end else if (el_attach >= TIME_W'(handover_reg) && dual_reg) begin
                cmd_next = CMD_SINK;
                if (ctrl_mode_reg) begin
                    sink_vld_next  = 1'b1;
                    sink_time_next = now_reg;
                end
            end
        end else begin
            // port looks empty: return to dual after the release time
            attach_vld_next = 1'b0;
            if (ctrl_mode_reg) begin
                if (sink_vld_reg && el_sink < TIME_W'(window)) begin
                    empty = 1'b0;
                end else begin
                    empty = !vbus_reg;
                end
            end
            if (!empty) begin
                empty_vld_next = 1'b0;
            end else begin
                if (!empty_vld_reg) begin
                    empty_vld_next  = 1'b1;
                    empty_time_next = now_reg;
                end
                if ((!empty_vld_reg || el_empty >= TIME_W'(release_reg)) && !dual_reg) begin
                    if (empty_vld_reg || release_reg == '0) begin
                        cmd_next = CMD_DUAL;
                    end
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            attach_vld_reg  <= 1'b0;
            attach_time_reg <= '0;
            empty_vld_reg   <= 1'b0;
            empty_time_reg  <= '0;
            sink_vld_reg    <= 1'b0;
            sink_time_reg   <= '0;
            untrusted_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_vld_reg <= s_valid;
            end
            if (proc) begin
                out_vld_reg     <= 1'b1;
                attach_vld_reg  <= attach_vld_next;
                attach_time_reg <= attach_time_next;
                empty_vld_reg   <= empty_vld_next;
                empty_time_reg  <= empty_time_next;
                sink_vld_reg    <= sink_vld_next;
                sink_time_reg   <= sink_time_next;
                untrusted_reg   <= untrusted_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            audio_reg    <= s_audio_present;
            partner_reg  <= s_typec_partner;
            host_bus_reg <= s_host_bus_device;
            id_host_reg  <= s_id_line_host;
            vbus_reg     <= s_vbus_present;
            dual_reg     <= s_port_is_dual_now;
            now_reg      <= s_now_seconds;
        end
        if (proc) begin
            cmd_reg      <= cmd_next;
            distrust_reg <= untrusted_next;
        end
    end

endmodule
